// File: rtl/mdag_pkg.sv
// shared types and constants for the stereo-match dma descriptor generator
// no dependencies; imported by every module of the block
`default_nettype none

package mdag_pkg;

  localparam int unsigned AddrW       = 32;
  localparam int unsigned IdxW        = 32;
  // descriptors per pixel is at most 15*15 + 15*255 + 3, which fits 12 bits
  localparam int unsigned RemW        = 12;
  // second division: divisor is the mask side or match width (8 bits)
  localparam int unsigned SubRemW     = 8;
  // row number inside the mask or match window is below the mask side
  localparam int unsigned SubQW       = 4;
  localparam int unsigned FrontStages = IdxW;
  localparam int unsigned BackStages  = RemW;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned QueuePtrW   = $clog2(QueueDepth);
  localparam int unsigned QueueCntW   = $clog2(QueueDepth + 1);
  localparam int unsigned StrideShift = 6;
  localparam logic [AddrW-1:0] DescStride = AddrW'(64);
  localparam logic [RemW-1:0]  ExtraDescs = RemW'(3);

  localparam logic [AddrW-1:0] MaskPosBase  = 32'd303038464;
  localparam logic [AddrW-1:0] MatchPosBase = 32'd304087040;

  localparam logic [3:0]  MaskSideRst     = 4'd3;
  localparam logic [7:0]  MatchWidthRst   = 8'd10;
  localparam logic [15:0] PictureWidthRst = 16'd30;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MASK_SIDE        = 3'd0,
    CFG_MATCH_WIDTH      = 3'd1,
    CFG_PICTURE_WIDTH    = 3'd2,
    CFG_DESCRIPTOR_BASE  = 3'd3,
    CFG_LEFT_IMAGE_BASE  = 3'd4,
    CFG_RIGHT_IMAGE_BASE = 3'd5,
    CFG_RESULT_BASE      = 3'd6,
    CFG_UNIT_BASE        = 3'd7
  } cfg_idx_e;

  typedef enum logic [4:0] {
    REGION_MASK      = 5'b00001,
    REGION_MATCH     = 5'b00010,
    REGION_MASK_POS  = 5'b00100,
    REGION_MATCH_POS = 5'b01000,
    REGION_RESULT    = 5'b10000
  } region_e;

  typedef struct packed {
    logic [3:0]       mask_side;
    logic [7:0]       match_width;
    logic [15:0]      picture_width;
    logic [AddrW-1:0] descriptor_base;
    logic [AddrW-1:0] left_image_base;
    logic [AddrW-1:0] right_image_base;
    logic [AddrW-1:0] result_base;
    logic [AddrW-1:0] unit_base;
    logic [7:0]       mask_area;
    logic [RemW-1:0]  window_area;
    logic [RemW-1:0]  per_pixel;
  } cfg_t;

  typedef struct packed {
    logic [IdxW-1:0]  pixel;
    logic [RemW-1:0]  slot;
    region_e          region;
    logic [AddrW-1:0] own_addr;
    logic [AddrW-1:0] next_addr;
  } desc_t;

endpackage

`default_nettype wire

// File: rtl/mdag_front.sv
// front end: accepts requests, splits the index into pixel and slot, classifies the slot
// depends on mdag_pkg; one restoring division step per pipeline stage
`default_nettype none

module mdag_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mdag_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [31:0]       descriptor_index_i,
  input  logic              is_last_i,
  output logic              push_o,
  output mdag_pkg::desc_t   push_data_o,
  input  logic              full_i
);
  import mdag_pkg::*;

  logic [FrontStages-1:0] vld_q;
  logic [RemW-1:0]        rem_q  [FrontStages];
  logic [IdxW-1:0]        dq_q   [FrontStages];
  logic [AddrW-1:0]       own_q  [FrontStages];
  logic [AddrW-1:0]       next_q [FrontStages];
  logic                   en;
  logic [AddrW-1:0]       own_d;
  logic [AddrW-1:0]       next_d;
  logic [RemW-1:0]        slot;
  logic [RemW-1:0]        loads_end;
  region_e                region;

  assign en         = !vld_q[FrontStages-1] || !full_i;
  assign in_stall_o = !en;
  assign push_o     = vld_q[FrontStages-1] && !full_i;

  assign own_d  = cfg_i.descriptor_base + (descriptor_index_i << StrideShift);
  assign next_d = is_last_i ? cfg_i.descriptor_base : own_d + DescStride;

  for (genvar s = 0; s < FrontStages; s++) begin : g_stage
    logic [RemW-1:0]  rem_in;
    logic [IdxW-1:0]  dq_in;
    logic [RemW:0]    trial;
    logic             ge;
    logic [RemW-1:0]  rem_d;
    logic [IdxW-1:0]  dq_d;
    logic             vld_d;
    logic [AddrW-1:0] own_in;
    logic [AddrW-1:0] next_in;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign dq_in   = descriptor_index_i;
      assign vld_d   = in_valid_i;
      assign own_in  = own_d;
      assign next_in = next_d;
    end else begin : g_rest
      assign rem_in  = rem_q[s-1];
      assign dq_in   = dq_q[s-1];
      assign vld_d   = vld_q[s-1];
      assign own_in  = own_q[s-1];
      assign next_in = next_q[s-1];
    end

    assign trial = {rem_in, dq_in[IdxW-1]};
    assign ge    = trial >= {1'b0, cfg_i.per_pixel};
    assign rem_d = ge ? RemW'(trial - {1'b0, cfg_i.per_pixel}) : trial[RemW-1:0];
    assign dq_d  = {dq_in[IdxW-2:0], ge};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en) begin
        vld_q[s] <= vld_d;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[s]  <= rem_d;
        dq_q[s]   <= dq_d;
        own_q[s]  <= own_in;
        next_q[s] <= next_in;
      end
    end
  end

  // slot order: mask loads, match loads, mask pos, match pos, result
  assign slot      = rem_q[FrontStages-1];
  assign loads_end = RemW'(cfg_i.mask_area) + cfg_i.window_area;

  always_comb begin
    if (slot < RemW'(cfg_i.mask_area)) begin
      region = REGION_MASK;
    end else if (slot < loads_end) begin
      region = REGION_MATCH;
    end else if (slot == loads_end) begin
      region = REGION_MASK_POS;
    end else if (slot == loads_end + RemW'(1)) begin
      region = REGION_MATCH_POS;
    end else begin
      region = REGION_RESULT;
    end
  end

  assign push_data_o.pixel     = dq_q[FrontStages-1];
  assign push_data_o.slot      = slot;
  assign push_data_o.region    = region;
  assign push_data_o.own_addr  = own_q[FrontStages-1];
  assign push_data_o.next_addr = next_q[FrontStages-1];

endmodule

`default_nettype wire

// File: rtl/mdag_queue.sv
// short register queue between the front and back pipelines
// depends on mdag_pkg for the entry type and depth
`default_nettype none

module mdag_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mdag_pkg::desc_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output mdag_pkg::desc_t pop_data_o
);
  import mdag_pkg::*;

  desc_t                entry_q [QueueDepth];
  logic [QueuePtrW-1:0] head_q, head_d;
  logic [QueuePtrW-1:0] tail_q, tail_d;
  logic [QueueCntW-1:0] cnt_q, cnt_d;

  assign full_o     = cnt_q == QueueCntW'(QueueDepth);
  assign empty_o    = cnt_q == '0;
  assign pop_data_o = entry_q[head_q];

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      tail_d = tail_q + QueuePtrW'(1);
    end
    if (pop_i) begin
      head_d = head_q + QueuePtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QueueCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QueueCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[tail_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/mdag_back.sv
// back end: splits the slot into row and column and forms source and destination
// depends on mdag_pkg; one division step per stage, then an output register
`default_nettype none

module mdag_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mdag_pkg::cfg_t    cfg_i,
  input  logic              empty_i,
  output logic              pop_o,
  input  mdag_pkg::desc_t   pop_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [31:0]       own_address_o,
  output logic [31:0]       next_address_o,
  output logic [31:0]       source_address_o,
  output logic [31:0]       dest_address_o
);
  import mdag_pkg::*;

  logic [BackStages-1:0] vld_q;
  logic [SubRemW-1:0]    rem_q  [BackStages];
  logic [RemW-1:0]       dq_q   [BackStages];
  desc_t                 desc_q [BackStages];
  logic                  out_valid_q;
  logic [AddrW-1:0]      own_q, next_q, src_q, dst_q;
  logic [AddrW-1:0]      src_d, dst_d;
  logic                  en;
  logic [RemW-1:0]       dividend;
  logic [SubQW-1:0]      row;
  logic [19:0]           line_off;
  logic [AddrW-1:0]      col;
  desc_t                 tail;

  assign en    = !out_valid_q || !out_stall_i;
  assign pop_o = en && !empty_i;

  // match slots are counted from the end of the mask loads
  assign dividend = (pop_data_i.region == REGION_MATCH) ?
                    pop_data_i.slot - RemW'(cfg_i.mask_area) : pop_data_i.slot;

  for (genvar s = 0; s < BackStages; s++) begin : g_stage
    logic [SubRemW-1:0] rem_in;
    logic [RemW-1:0]    dq_in;
    logic [SubRemW:0]   trial;
    logic               ge;
    logic [SubRemW-1:0] rem_d;
    logic [RemW-1:0]    dq_d;
    logic               vld_d;
    desc_t              desc_in;
    logic [SubRemW-1:0] div_s;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign dq_in   = dividend;
      assign vld_d   = !empty_i;
      assign desc_in = pop_data_i;
    end else begin : g_rest
      assign rem_in  = rem_q[s-1];
      assign dq_in   = dq_q[s-1];
      assign vld_d   = vld_q[s-1];
      assign desc_in = desc_q[s-1];
    end

    // divisor follows from the region carried with the item
    assign div_s = (desc_in.region == REGION_MASK) ?
                   SubRemW'(cfg_i.mask_side) : cfg_i.match_width;

    assign trial = {rem_in, dq_in[RemW-1]};
    assign ge    = trial >= {1'b0, div_s};
    assign rem_d = ge ? SubRemW'(trial - {1'b0, div_s}) : trial[SubRemW-1:0];
    assign dq_d  = {dq_in[RemW-2:0], ge};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en) begin
        vld_q[s] <= vld_d;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q[s]  <= rem_d;
        dq_q[s]   <= dq_d;
        desc_q[s] <= desc_in;
      end
    end
  end

  assign tail     = desc_q[BackStages-1];
  assign row      = dq_q[BackStages-1][SubQW-1:0];
  assign line_off = 20'(row) * 20'(cfg_i.picture_width);
  assign col      = AddrW'(rem_q[BackStages-1]);

  always_comb begin
    src_d = cfg_i.unit_base;
    dst_d = cfg_i.unit_base + AddrW'(tail.slot);
    case (tail.region)
      REGION_MASK: begin
        src_d = cfg_i.left_image_base + col + AddrW'(line_off) + tail.pixel;
      end
      REGION_MATCH: begin
        src_d = cfg_i.right_image_base + col + AddrW'(line_off);
      end
      REGION_MASK_POS: begin
        src_d = MaskPosBase + tail.pixel;
      end
      REGION_MATCH_POS: begin
        src_d = MatchPosBase + tail.pixel;
      end
      REGION_RESULT: begin
        dst_d = cfg_i.result_base + tail.pixel;
      end
      default: begin
        dst_d = cfg_i.result_base + tail.pixel;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[BackStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      own_q  <= tail.own_addr;
      next_q <= tail.next_addr;
      src_q  <= src_d;
      dst_q  <= dst_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign own_address_o    = own_q;
  assign next_address_o   = next_q;
  assign source_address_o = src_q;
  assign dest_address_o   = dst_q;

endmodule

`default_nettype wire

// File: rtl/match_dma_descriptor_address_gen.sv
// Descriptor address generator for the stereo matching dma ring. Takes one
// descriptor index per cycle while in_stall_o is low and returns its own, next,
// source and destination word addresses, one result per cycle while out_stall_i
// is low. The index passes through 32 stages that split it into pixel and slot
// (one quotient bit per stage), a 4-entry queue, 12 stages that split the slot
// into row and column, and the output register. Configuration registers are written
// through the cfg port, which is always ready; write them only with the pipeline empty.
// depends on mdag_pkg, mdag_front, mdag_queue, mdag_back
`default_nettype none

module match_dma_descriptor_address_gen (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] descriptor_index_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] own_address_o,
  output logic [31:0] next_address_o,
  output logic [31:0] source_address_o,
  output logic [31:0] dest_address_o
);
  import mdag_pkg::*;

  logic [3:0]       mask_side_q;
  logic [7:0]       match_width_q;
  logic [15:0]      picture_width_q;
  logic [AddrW-1:0] descriptor_base_q;
  logic [AddrW-1:0] left_image_base_q;
  logic [AddrW-1:0] right_image_base_q;
  logic [AddrW-1:0] result_base_q;
  logic [AddrW-1:0] unit_base_q;
  cfg_t             cfg;
  logic [7:0]       mask_area;
  logic [RemW-1:0]  window_area;
  logic             push;
  logic             pop;
  logic             full;
  logic             empty;
  desc_t            push_data;
  desc_t            pop_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_side_q        <= MaskSideRst;
      match_width_q      <= MatchWidthRst;
      picture_width_q    <= PictureWidthRst;
      descriptor_base_q  <= '0;
      left_image_base_q  <= '0;
      right_image_base_q <= '0;
      result_base_q      <= '0;
      unit_base_q        <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MASK_SIDE:        mask_side_q        <= cfg_data_i[3:0];
        CFG_MATCH_WIDTH:      match_width_q      <= cfg_data_i[7:0];
        CFG_PICTURE_WIDTH:    picture_width_q    <= cfg_data_i[15:0];
        CFG_DESCRIPTOR_BASE:  descriptor_base_q  <= cfg_data_i;
        CFG_LEFT_IMAGE_BASE:  left_image_base_q  <= cfg_data_i;
        CFG_RIGHT_IMAGE_BASE: right_image_base_q <= cfg_data_i;
        CFG_RESULT_BASE:      result_base_q      <= cfg_data_i;
        CFG_UNIT_BASE:        unit_base_q        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign mask_area   = 8'(mask_side_q) * 8'(mask_side_q);
  assign window_area = RemW'(mask_side_q) * RemW'(match_width_q);

  assign cfg.mask_side        = mask_side_q;
  assign cfg.match_width      = match_width_q;
  assign cfg.picture_width    = picture_width_q;
  assign cfg.descriptor_base  = descriptor_base_q;
  assign cfg.left_image_base  = left_image_base_q;
  assign cfg.right_image_base = right_image_base_q;
  assign cfg.result_base      = result_base_q;
  assign cfg.unit_base        = unit_base_q;
  assign cfg.mask_area        = mask_area;
  assign cfg.window_area      = window_area;
  assign cfg.per_pixel        = RemW'(mask_area) + window_area + ExtraDescs;

  mdag_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .descriptor_index_i (descriptor_index_i),
    .is_last_i          (is_last_i),
    .push_o             (push),
    .push_data_o        (push_data),
    .full_i             (full)
  );

  mdag_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_data)
  );

  mdag_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .empty_i          (empty),
    .pop_o            (pop),
    .pop_data_i       (pop_data),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .own_address_o    (own_address_o),
    .next_address_o   (next_address_o),
    .source_address_o (source_address_o),
    .dest_address_o   (dest_address_o)
  );

endmodule

`default_nettype wire

// File: rtl/mdag_checker.sv
// port-level checks for the descriptor address generator, bound to the top level
// depends on mdag_pkg and match_dma_descriptor_address_gen
`default_nettype none

module mdag_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [2:0]  cfg_index_i,
  input logic [31:0] cfg_data_i,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [31:0] descriptor_index_i,
  input logic        is_last_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] own_address_o,
  input logic [31:0] next_address_o,
  input logic [31:0] source_address_o,
  input logic [31:0] dest_address_o
);
  import mdag_pkg::*;

  logic [AddrW-1:0] base_q;
  logic [AddrW-1:0] own_off;

  // shadow of the ring base as written through the config port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o &&
                 cfg_idx_e'(cfg_index_i) == CFG_DESCRIPTOR_BASE) begin
      base_q <= cfg_data_i;
    end
  end

  assign own_off = own_address_o - base_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(own_address_o) && $stable(next_address_o)
      && $stable(source_address_o) && $stable(dest_address_o))
    else $error("stalled result changed");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write refused");

  a_own_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> own_off[StrideShift-1:0] == '0)
    else $error("descriptor address off the ring stride");

  a_next_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> next_address_o == base_q || next_address_o == own_address_o + DescStride)
    else $error("next descriptor address neither base nor following slot");

endmodule

bind match_dma_descriptor_address_gen mdag_checker u_mdag_checker (.*);

`default_nettype wire

// File: tb/sv/tb_match_dma_descriptor_address_gen.sv
// self-checking testbench for match_dma_descriptor_address_gen
// depends on mdag_pkg and the rtl of the block; directed table, then random requests
`default_nettype none

module tb_match_dma_descriptor_address_gen;
  import mdag_pkg::*;

  typedef struct packed {
    logic [31:0] own;
    logic [31:0] nxt;
    logic [31:0] src;
    logic [31:0] dst;
  } desc_addr_t;

  typedef struct {
    logic [31:0] idx;
    logic        last;
    logic        typed;
    desc_addr_t  res;
  } stim_row_t;

  localparam int unsigned Latency = 46;
  localparam int unsigned NumRandom = 1430;

  logic        clk_i, rst_ni;
  logic        cfg_valid_i, cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i, in_stall_o;
  logic [31:0] descriptor_index_i;
  logic        is_last_i;
  logic        out_valid_o, out_stall_i;
  logic [31:0] own_address_o, next_address_o, source_address_o, dest_address_o;

  // shadow copy of the configuration
  logic [3:0]  mask_side;
  logic [7:0]  match_width;
  logic [15:0] picture_width;
  logic [31:0] desc_base, left_base, right_base, res_base, unit_base;

  desc_addr_t expected_q[$];
  int errors, checked, accepted;
  bit quiet;     // no idling in the final stretch
  bit hold_long; // receiver holds off for a long stretch

  match_dma_descriptor_address_gen i_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic desc_addr_t predict_descriptor(logic [31:0] idx, logic last);
    desc_addr_t r;
    logic [31:0] s, w, sq, win, per, pixel, d, o;
    s = 32'(mask_side);
    w = 32'(match_width);
    sq = s * s;
    win = s * w;
    per = sq + win + 32'd3;
    pixel = idx / per;
    d = idx % per;
    r.own = desc_base + (idx << 6);
    r.nxt = last ? desc_base : desc_base + ((idx + 32'd1) << 6);
    if (d < sq && s != 0) begin
      r.src = left_base + d % s + (d / s) * 32'(picture_width) + pixel;
      r.dst = unit_base + d;
    end else if (d < sq + win && w != 0) begin
      o = d - sq;
      r.src = right_base + o % w + (o / w) * 32'(picture_width);
      r.dst = unit_base + d;
    end else if (d == sq + win) begin
      r.src = MaskPosBase + pixel;
      r.dst = unit_base + d;
    end else if (d == sq + win + 32'd1) begin
      r.src = MatchPosBase + pixel;
      r.dst = unit_base + d;
    end else begin
      r.src = unit_base;
      r.dst = res_base + pixel;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MASK_SIDE:        mask_side = val[3:0];
      CFG_MATCH_WIDTH:      match_width = val[7:0];
      CFG_PICTURE_WIDTH:    picture_width = val[15:0];
      CFG_DESCRIPTOR_BASE:  desc_base = val;
      CFG_LEFT_IMAGE_BASE:  left_base = val;
      CFG_RIGHT_IMAGE_BASE: right_base = val;
      CFG_RESULT_BASE:      res_base = val;
      default:              unit_base = val;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    while (expected_q.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    if (expected_q.size() != 0) begin
      $display("Verification failed");
      $finish;
    end
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  // sends one request; the valid stays high between back-to-back requests
  task automatic send_request(logic [31:0] idx, logic last, bit may_idle);
    if (may_idle && !quiet && $urandom_range(0, 5) == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3) - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    descriptor_index_i <= idx;
    is_last_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    expected_q.push_back(predict_descriptor(idx, last));
    accepted++;
  endtask

  task automatic end_burst();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // receiver stalls
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        out_stall_i <= 1'b1;
        repeat (120) @(negedge clk_i);
        out_stall_i <= 1'b0;
        hold_long = 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3) - 1) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    desc_addr_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result own", own_address_o, 32'h0);
      end else begin
        e = expected_q.pop_front();
        checked++;
        if (own_address_o !== e.own) report_mismatch("own_address", own_address_o, e.own);
        if (next_address_o !== e.nxt) report_mismatch("next_address", next_address_o, e.nxt);
        if (source_address_o !== e.src)
          report_mismatch("source_address", source_address_o, e.src);
        if (dest_address_o !== e.dst) report_mismatch("dest_address", dest_address_o, e.dst);
      end
    end
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    desc_addr_t got;
    logic [31:0] per, pix;
    int n;
    bit well_formed;

    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_MASK_SIDE;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    descriptor_index_i = '0;
    is_last_i = 1'b0;
    quiet = 1'b0;
    hold_long = 1'b0;
    errors = 0;
    checked = 0;
    accepted = 0;
    mask_side = MaskSideRst;
    match_width = MatchWidthRst;
    picture_width = PictureWidthRst;
    {desc_base, left_base, right_base, res_base, unit_base} = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // after reset: S=3, W=10, pitch 30, all bases zero, 42 descriptors per pixel
    rows = '{
      '{32'd0,  1'b0, 1'b1, '{32'h0,   32'h40,  32'd0,         32'd0}},
      '{32'd4,  1'b0, 1'b1, '{32'h100, 32'h140, 32'd31,        32'd4}},
      '{32'd9,  1'b0, 1'b1, '{32'h240, 32'h280, 32'd0,         32'd9}},
      '{32'd39, 1'b0, 1'b1, '{32'h9c0, 32'ha00, MaskPosBase,   32'd39}},
      '{32'd40, 1'b1, 1'b1, '{32'ha00, 32'h0,   MatchPosBase,  32'd40}},
      '{32'd41, 1'b0, 1'b1, '{32'ha40, 32'ha80, 32'd0,         32'd0}},
      '{32'd42, 1'b0, 1'b1, '{32'ha80, 32'hac0, 32'd1,         32'd0}},
      '{32'hffffffff, 1'b0, 1'b1, '{32'hffffffc0, 32'h0, 32'h0, 32'h0}},
      '{32'hffffffff, 1'b1, 1'b0, '{32'h0, 32'h0, 32'h0, 32'h0}},
      '{32'h7fffffff, 1'b0, 1'b0, '{32'h0, 32'h0, 32'h0, 32'h0}},
      '{32'd20, 1'b1, 1'b0, '{32'h0, 32'h0, 32'h0, 32'h0}}
    };
    // index wrap: mask load of pixel 0x6186186 slot 3, second mask row
    rows[7].res.src = 32'd30 + 32'h6186186;
    rows[7].res.dst = 32'd3;
    foreach (rows[k]) begin
      row = rows[k];
      if (row.typed) begin
        got = predict_descriptor(row.idx, row.last);
        if (got != row.res) report_mismatch("directed table", got.src, row.res.src);
      end
      send_request(row.idx, row.last, 1'b0);
    end
    end_burst();
    wait_drained();

    // zero mask side, zero match width, then extremes and random settings
    for (int phase = 0; phase < 12; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_MASK_SIDE, 32'd0);
          write_reg(CFG_UNIT_BASE, 32'hffffffff);
          write_reg(CFG_RESULT_BASE, 32'hfffffff0);
        end
        1: begin
          write_reg(CFG_MASK_SIDE, 32'd2);
          write_reg(CFG_MATCH_WIDTH, 32'd0);
        end
        2: begin
          write_reg(CFG_MASK_SIDE, 32'd15);
          write_reg(CFG_MATCH_WIDTH, 32'd255);
          write_reg(CFG_PICTURE_WIDTH, 32'd65535);
          write_reg(CFG_DESCRIPTOR_BASE, 32'hffffffff);
          write_reg(CFG_LEFT_IMAGE_BASE, 32'hffffffff);
          write_reg(CFG_RIGHT_IMAGE_BASE, 32'hffffffff);
        end
        3: begin
          write_reg(CFG_MASK_SIDE, 32'd1);
          write_reg(CFG_MATCH_WIDTH, 32'd1);
          write_reg(CFG_PICTURE_WIDTH, 32'd1);
          write_reg(CFG_DESCRIPTOR_BASE, 32'd0);
          write_reg(CFG_LEFT_IMAGE_BASE, 32'd0);
          write_reg(CFG_RIGHT_IMAGE_BASE, 32'd0);
          write_reg(CFG_RESULT_BASE, 32'd0);
          write_reg(CFG_UNIT_BASE, 32'd0);
        end
        default: begin
          write_reg(CFG_MASK_SIDE, $urandom_range(0, 15));
          write_reg(CFG_MATCH_WIDTH, $urandom_range(0, 5) == 0 ? 0 : $urandom_range(1, 255));
          write_reg(CFG_PICTURE_WIDTH, $urandom_range(0, 65535));
          write_reg(CFG_DESCRIPTOR_BASE, $urandom());
          write_reg(CFG_LEFT_IMAGE_BASE, $urandom());
          write_reg(CFG_RIGHT_IMAGE_BASE, $urandom());
          write_reg(CFG_RESULT_BASE, $urandom());
          write_reg(CFG_UNIT_BASE, $urandom());
        end
      endcase
      if (phase == 5) hold_long = 1'b1;
      if (phase == 11) quiet = 1'b1;
      per = 32'(mask_side) * 32'(mask_side) + 32'(mask_side) * 32'(match_width) + 32'd3;
      n = (phase == 2) ? 60 : NumRandom / 10;
      for (int k = 0; k < n; k++) begin
        well_formed = $urandom_range(0, 3) != 0;
        if (well_formed) begin
          // a slot of a random pixel, covering every region
          pix = $urandom_range(0, 3) == 0 ? $urandom() / per : $urandom_range(0, 2000);
          send_request(pix * per + $urandom_range(0, per - 1), $urandom_range(0, 1), 1'b1);
        end else begin
          send_request($urandom(), $urandom_range(0, 1), 1'b1);
        end
      end
      end_burst();
      wait_drained();
    end

    $display("covered %0d descriptor requests over 13 settings, %0d results compared",
             accepted, checked);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
